FILE: design/mbde_pkg.sv
// Shared types, field widths and register codes of the button debounce event scanner.
package mbde_pkg;

  // Default number of scanned buttons.
  localparam int unsigned NumButtonsDefault = 14;
  // Depth of the tick queue between the front and back ends.
  localparam int unsigned TickQueueDepth = 2;

  // Field widths.
  localparam int unsigned LevelW = 14;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned PitchW = 14;
  localparam int unsigned ThrW = 4;
  localparam int unsigned IdW = 4;
  localparam int unsigned ValueW = 16;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 14;

  // Stream bus widths.
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 24;

  // Register reset values.
  localparam logic [LevelW-1:0] FastMaskRst = 14'd992;
  localparam logic [ThrW-1:0] NormalTicksRst = 4'd3;
  localparam logic [ThrW-1:0] FastTicksRst = 4'd1;
  localparam logic [ThrW-1:0] PitchPeriodRst = 4'd2;

  // Event identifiers of the non-button events.
  localparam logic [IdW-1:0] IdJog = 4'd0;
  localparam logic [IdW-1:0] IdBrowse = 4'd1;
  localparam logic [IdW-1:0] IdPitch = 4'd0;

  typedef enum logic [1:0] {
    KindButton = 2'd0,
    KindJog    = 2'd1,
    KindBrowse = 2'd2,
    KindPitch  = 2'd3
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFastMask    = 2'd0,
    CfgNormalTicks = 2'd1,
    CfgFastTicks   = 2'd2,
    CfgPitchPeriod = 2'd3
  } cfg_reg_e;

  // Non-button part of one classified tick: pending flags and payloads.
  typedef struct packed {
    logic                     jog_ev;
    logic signed [DeltaW-1:0] jog;
    logic                     browse_ev;
    logic signed [DeltaW-1:0] browse;
    logic                     pitch_ev;
    logic [PitchW-1:0]        pitch;
  } tick_rec_t;

endpackage

FILE: design/multi_button_debounce_event_scanner.sv
// Top level of the multi-button debounce and event scanner.
// Each accepted scan tick updates the debounce counters of all buttons and the
// pitch phase in the cycle it is taken, so a tick can be accepted every cycle
// while the two-entry tick queue has room. The back end then sends the tick's
// events, one per cycle while the output is not stalled: button flips by rising
// index, jog, browse, pitch, with tlast on the final one. A tick holds at most
// NUM_BUTTONS + 3 events; a tick with no events passes through the back end
// and emits nothing. The tick queue absorbs bursts while the back end drains.
module multi_button_debounce_event_scanner #(
  parameter int unsigned NUM_BUTTONS = mbde_pkg::NumButtonsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbde_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mbde_pkg::CfgDataW-1:0]   cfg_data_i,
  // Scan tick stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: button_levels[13:0], jog_delta[29:14], browse_delta[45:30],
  // pitch_sample[59:46], zero[63:60].
  input  logic [mbde_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: pitch_ok[0].
  input  logic                            s_axis_tuser,
  // Event stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: event_id[3:0], event_value[19:4], zero[23:20].
  output logic [mbde_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: event_kind[1:0].
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import mbde_pkg::*;

  localparam int unsigned RecW = $bits(tick_rec_t);
  localparam int unsigned QW   = 2 * NUM_BUTTONS + RecW;

  logic                     push, push_ready, head_valid, pop;
  logic [NUM_BUTTONS-1:0]   flip, press, head_flip, head_press;
  tick_rec_t                rec, head_rec;
  logic [QW-1:0]            push_data, head_data;
  event_kind_e              out_kind;
  logic [IdW-1:0]           out_id;
  logic signed [ValueW-1:0] out_value;

  mbde_front #(
    .NumButtons(NUM_BUTTONS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .button_levels_i(s_axis_tdata[13:0]),
    .jog_delta_i    (s_axis_tdata[29:14]),
    .browse_delta_i (s_axis_tdata[45:30]),
    .pitch_sample_i (s_axis_tdata[59:46]),
    .pitch_ok_i     (s_axis_tuser),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .flip_o         (flip),
    .press_o        (press),
    .rec_o          (rec)
  );

  assign push_data = {flip, press, rec};
  assign {head_flip, head_press, head_rec} = head_data;

  mbde_fifo #(
    .Width(QW),
    .Depth(TickQueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_data_o (head_data)
  );

  mbde_back #(
    .NumButtons(NUM_BUTTONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .head_flip_i (head_flip),
    .head_press_i(head_press),
    .head_rec_i  (head_rec),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_id_o    (out_id),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the event fields onto the output bus.
  assign m_axis_tdata = {(OutDataW - IdW - ValueW)'(0), out_value, out_id};
  assign m_axis_tuser = out_kind;

endmodule

FILE: design/mbde_front.sv
// Front end: configuration registers, per-button debounce counters and pitch phase.
module mbde_front #(
  parameter int unsigned NumButtons = mbde_pkg::NumButtonsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbde_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mbde_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mbde_pkg::LevelW-1:0]         button_levels_i,
  input  logic signed [mbde_pkg::DeltaW-1:0]  jog_delta_i,
  input  logic signed [mbde_pkg::DeltaW-1:0]  browse_delta_i,
  input  logic [mbde_pkg::PitchW-1:0]         pitch_sample_i,
  input  logic                                pitch_ok_i,
  output logic                                push_o,
  input  logic                                push_ready_i,
  output logic [NumButtons-1:0]               flip_o,
  output logic [NumButtons-1:0]               press_o,
  output mbde_pkg::tick_rec_t                 rec_o
);
  import mbde_pkg::*;

  logic [LevelW-1:0] fast_mask_q;
  logic [ThrW-1:0]   normal_ticks_q, fast_ticks_q, pitch_period_q;
  logic [ThrW-1:0]   normal_thr, fast_thr, period_eff;
  logic [NumButtons-1:0] raw_pressed, fast_sel, conf_q, conf_d;
  logic [ThrW-1:0]   cnt_q [NumButtons];
  logic [ThrW-1:0]   cnt_d [NumButtons];
  logic [ThrW-1:0]   phase_q, phase_d, phase_inc;
  logic              pitch_tick;
  logic              accept;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_mask_q    <= FastMaskRst;
      normal_ticks_q <= NormalTicksRst;
      fast_ticks_q   <= FastTicksRst;
      pitch_period_q <= PitchPeriodRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgFastMask:    fast_mask_q    <= cfg_data_i[LevelW-1:0];
        CfgNormalTicks: normal_ticks_q <= cfg_data_i[ThrW-1:0];
        CfgFastTicks:   fast_ticks_q   <= cfg_data_i[ThrW-1:0];
        CfgPitchPeriod: pitch_period_q <= cfg_data_i[ThrW-1:0];
        default:        fast_mask_q    <= fast_mask_q;
      endcase
    end
  end

  // A zero threshold or period behaves as one.
  assign normal_thr = (normal_ticks_q == '0) ? ThrW'(1) : normal_ticks_q;
  assign fast_thr   = (fast_ticks_q == '0) ? ThrW'(1) : fast_ticks_q;
  assign period_eff = (pitch_period_q == '0) ? ThrW'(1) : pitch_period_q;

  // A tick is taken whenever the queue has room.
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  // Buttons beyond the level field read as pressed with the normal threshold.
  for (genvar g = 0; g < NumButtons; g++) begin : g_btn
    if (g < LevelW) begin : g_in
      assign raw_pressed[g] = ~button_levels_i[g];
      assign fast_sel[g]    = fast_mask_q[g];
    end else begin : g_out
      assign raw_pressed[g] = 1'b1;
      assign fast_sel[g]    = 1'b0;
    end

    // Count differing scans; flip the confirmed state at the threshold.
    always_comb begin
      logic [ThrW-1:0] thr;
      logic [ThrW-1:0] cnt_inc;
      thr      = fast_sel[g] ? fast_thr : normal_thr;
      cnt_inc  = cnt_q[g] + ThrW'(1);
      conf_d[g] = conf_q[g];
      flip_o[g] = 1'b0;
      if (raw_pressed[g] == conf_q[g]) begin
        cnt_d[g] = '0;
      end else if (cnt_inc >= thr) begin
        cnt_d[g]  = '0;
        conf_d[g] = raw_pressed[g];
        flip_o[g] = 1'b1;
      end else begin
        cnt_d[g] = cnt_inc;
      end
    end
  end

  assign press_o = raw_pressed;

  // Pitch phase advances every tick and clears on a pitch tick.
  assign phase_inc  = phase_q + ThrW'(1);
  assign pitch_tick = (phase_inc >= period_eff);
  assign phase_d    = pitch_tick ? '0 : phase_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q  <= '0;
      phase_q <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (accept) begin
      conf_q  <= conf_d;
      phase_q <= phase_d;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Classified tick record for the back end.
  always_comb begin
    rec_o.jog_ev    = (jog_delta_i != '0);
    rec_o.jog       = jog_delta_i;
    rec_o.browse_ev = (browse_delta_i != '0);
    rec_o.browse    = browse_delta_i;
    rec_o.pitch_ev  = pitch_tick && pitch_ok_i;
    rec_o.pitch     = pitch_sample_i;
  end

endmodule

FILE: design/mbde_fifo.sv
// Small register queue holding classified ticks between the front and back ends.
module mbde_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = mbde_pkg::TickQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             head_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] head_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != (PtrW+1)'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

FILE: design/mbde_back.sv
// Back end: serializes the events of each queued tick into the output register.
module mbde_back #(
  parameter int unsigned NumButtons = mbde_pkg::NumButtonsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               head_valid_i,
  output logic                               pop_o,
  input  logic [NumButtons-1:0]              head_flip_i,
  input  logic [NumButtons-1:0]              head_press_i,
  input  mbde_pkg::tick_rec_t                head_rec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output mbde_pkg::event_kind_e              out_kind_o,
  output logic [mbde_pkg::IdW-1:0]           out_id_o,
  output logic signed [mbde_pkg::ValueW-1:0] out_value_o,
  output logic                               out_last_o
);
  import mbde_pkg::*;

  logic [NumButtons-1:0] pend_q, press_q, lowest, pend_rem;
  tick_rec_t             work_q, work_rem;
  logic                  have_work, out_free, step, remaining, load;
  logic [IdxW-1:0]       idx;
  event_kind_e           ev_kind;
  logic [IdW-1:0]        ev_id;
  logic signed [ValueW-1:0] ev_value;

  logic                     out_valid_q, out_last_q;
  event_kind_e              out_kind_q;
  logic [IdW-1:0]           out_id_q;
  logic signed [ValueW-1:0] out_value_q;

  assign have_work = (|pend_q) || work_q.jog_ev || work_q.browse_ev || work_q.pitch_ev;
  assign out_free  = !out_valid_q || out_ready_i;
  assign step      = have_work && out_free;

  // Lowest pending button and its index.
  assign lowest = pend_q & (~pend_q + NumButtons'(1));
  always_comb begin
    idx = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (lowest[i]) begin
        idx = idx | IdxW'(i);
      end
    end
  end

  // Pick the next event: buttons by index, then jog, browse, pitch.
  always_comb begin
    pend_rem = pend_q;
    work_rem = work_q;
    ev_kind  = KindButton;
    ev_id    = idx[IdW-1:0];
    ev_value = '0;
    priority if (|pend_q) begin
      pend_rem = pend_q & ~lowest;
      ev_value = ValueW'(|(lowest & press_q));
    end else if (work_q.jog_ev) begin
      work_rem.jog_ev = 1'b0;
      ev_kind  = KindJog;
      ev_id    = IdJog;
      ev_value = work_q.jog;
    end else if (work_q.browse_ev) begin
      work_rem.browse_ev = 1'b0;
      ev_kind  = KindBrowse;
      ev_id    = IdBrowse;
      ev_value = work_q.browse;
    end else begin
      work_rem.pitch_ev = 1'b0;
      ev_kind  = KindPitch;
      ev_id    = IdPitch;
      ev_value = ValueW'(work_q.pitch);
    end
  end

  assign remaining = (|pend_rem) || work_rem.jog_ev || work_rem.browse_ev ||
                     work_rem.pitch_ev;
  assign load  = head_valid_i && (!have_work || (step && !remaining));
  assign pop_o = load;

  // Working tick: loaded from the queue, drained one event per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      press_q <= '0;
      work_q  <= '0;
    end else if (load) begin
      pend_q  <= head_flip_i;
      press_q <= head_press_i;
      work_q  <= head_rec_i;
    end else if (step) begin
      pend_q <= pend_rem;
      work_q <= work_rem;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_kind_q  <= ev_kind;
      out_id_q    <= ev_id;
      out_value_q <= ev_value;
      out_last_q  <= !remaining;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule
